// File: rtl/mhs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-heap scheduler package
// Shared constants, the heap entry type, the controller states and small
// helper functions for the job-to-machine scheduler.
// ----------------------------------------------------------------------------
package mhs_pkg;

  localparam int MAX_MACHINES   = 16;
  localparam int SLOT_W         = $clog2(MAX_MACHINES + 1);
  localparam int ADDR_W         = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
  localparam int CNT_W          = 5;
  localparam int ID_W           = 5;
  localparam int TIME_W         = 32;
  localparam int LEN_W          = 16;
  localparam int RESET_MACHINES = 3;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  localparam logic CMD_RESTART = 1'b0;
  localparam logic CMD_JOB     = 1'b1;

  typedef struct packed {
    logic [SLOT_W-1:0] id;
    logic [TIME_W-1:0] free_time;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_LAST,
    S_POP_INIT,
    S_DN_A,
    S_DN_B,
    S_DN_LAST,
    S_UP_START,
    S_UP,
    S_UP_LAST,
    S_EMIT
  } state_t;

  function automatic logic [ADDR_W-1:0] slot2addr(input logic [SLOT_W-1:0] slot);
    logic [SLOT_W-1:0] tmp;
    tmp = slot - SLOT_W'(1);
    return tmp[ADDR_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] clamp_count(input logic [CNT_W-1:0] n);
    logic [SLOT_W-1:0] res;
    if (n == '0) begin
      res = SLOT_W'(1);
    end else if (32'(n) > MAX_MACHINES) begin
      res = SLOT_W'(MAX_MACHINES);
    end else begin
      res = SLOT_W'(n);
    end
    return res;
  endfunction

endpackage

// File: rtl/mhs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mhs_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/min_heap_job_to_machine_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-heap job-to-machine scheduler
// Assigns each job to the machine that becomes free first, keeping the
// machines in a binary min-heap held in a single-port-read RAM.
// ----------------------------------------------------------------------------
// A restart transaction reloads machines 1..N, all free at time zero, and
// gives no result. A job transaction removes the heap root, reports
// its machine, start time and last time unit, adds the job length to that
// machine's free time and inserts it again. The time each job takes until the
// block is ready again is set by the heap RAM with its one read per cycle:
// two reads per level of the sift-down and one per level of the sift-up.
// The emit step also waits while the previous result still waits for
// out_ready. Only one transaction is in work at a time.
module min_heap_job_to_machine_scheduler_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [mhs_pkg::CNT_W-1:0]    cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_cmd,
  input  logic [mhs_pkg::LEN_W-1:0]    in_job_length,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mhs_pkg::ID_W-1:0]     out_machine_id,
  output logic [mhs_pkg::TIME_W-1:0]   out_start_time,
  output logic [mhs_pkg::TIME_W-1:0]   out_end_time
);

  localparam int SW = mhs_pkg::SLOT_W;
  localparam int TW = mhs_pkg::TIME_W;
  localparam int LW = mhs_pkg::LEN_W;

  mhs_pkg::state_t state_r, state_nxt;

  logic [mhs_pkg::CNT_W-1:0]        cfg_num_r;
  logic [SW-1:0]                    cnt_r, cnt_nxt;
  logic [mhs_pkg::MAX_MACHINES-1:0] valid_r, valid_nxt;
  logic [LW-1:0]                    len_r, len_nxt;
  mhs_pkg::entry_t                  top_r, top_nxt;
  mhs_pkg::entry_t                  last_r, last_nxt;
  mhs_pkg::entry_t                  ca_r, ca_nxt;
  logic [SW-1:0]                    parent_r, parent_nxt;
  logic [SW-1:0]                    child_r, child_nxt;
  logic [SW-1:0]                    idx_r, idx_nxt;
  logic [TW-1:0]                    mtime_r, mtime_nxt;
  logic [TW-1:0]                    end_r, end_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [mhs_pkg::ID_W-1:0]         out_id_r, out_id_nxt;
  logic [TW-1:0]                    out_start_r, out_start_nxt;
  logic [TW-1:0]                    out_end_r, out_end_nxt;
  logic [SW-1:0]                    rd_slot_r;
  logic                             rd_valid_r;

  logic                             wr_en;
  logic [SW-1:0]                    wr_slot;
  mhs_pkg::entry_t                  wr_data;
  logic [SW-1:0]                    rd_slot;
  logic [mhs_pkg::ENTRY_W-1:0]      ram_q;

  mhs_pkg::entry_t                  rd_entry;
  mhs_pkg::entry_t                  sel_entry;
  mhs_pkg::entry_t                  push_entry;
  logic [SW-1:0]                    sel_idx;
  logic [SW-1:0]                    pop_n;
  logic [SW:0]                      next_child;
  logic                             next_more;
  logic                             sel_stop;
  logic                             has_b;
  logic                             push_lt;
  logic [SW-1:0]                    up_idx;
  logic                             accept_in;
  logic                             emit_ok;
  logic [TW:0]                      sum_full;
  logic [TW:0]                      end_sum;
  logic [LW-1:0]                    len_m1;

  mhs_ram #(
    .WIDTH (mhs_pkg::ENTRY_W),
    .DEPTH (mhs_pkg::MAX_MACHINES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (mhs_pkg::slot2addr(wr_slot)),
    .wr_data (wr_data),
    .rd_addr (mhs_pkg::slot2addr(rd_slot)),
    .rd_data (ram_q)
  );

  // Slots never written since the last restart hold their machine at time zero.
  always_comb begin
    if (rd_valid_r) begin
      rd_entry = mhs_pkg::entry_t'(ram_q);
    end else begin
      rd_entry.id        = rd_slot_r;
      rd_entry.free_time = '0;
    end
  end

  assign accept_in  = in_valid && in_ready;
  assign emit_ok    = !out_valid_r || out_ready;
  assign pop_n      = cnt_r - SW'(1);
  assign has_b      = child_r < pop_n;
  assign push_lt    = mtime_r < rd_entry.free_time;
  assign up_idx     = idx_r >> 1;
  assign push_entry = '{id: top_r.id, free_time: mtime_r};

  always_comb begin
    if ((state_r == mhs_pkg::S_DN_B) && (ca_r.free_time > rd_entry.free_time)) begin
      sel_entry = rd_entry;
      sel_idx   = child_r + SW'(1);
    end else if (state_r == mhs_pkg::S_DN_B) begin
      sel_entry = ca_r;
      sel_idx   = child_r;
    end else begin
      sel_entry = rd_entry;
      sel_idx   = child_r;
    end
    sel_stop   = sel_entry.free_time > last_r.free_time;
    next_child = {sel_idx, 1'b0};
    next_more  = next_child <= {1'b0, pop_n};
  end

  assign len_m1   = len_r - LW'(1);
  assign sum_full = {1'b0, top_r.free_time} + (TW + 1)'(len_r);
  assign end_sum  = {1'b0, top_r.free_time} + (TW + 1)'(len_m1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mhs_pkg::S_IDLE: begin
        if (accept_in && (in_cmd == mhs_pkg::CMD_JOB)) begin
          state_nxt = mhs_pkg::S_RD_LAST;
        end
      end
      mhs_pkg::S_RD_LAST: begin
        state_nxt = mhs_pkg::S_POP_INIT;
      end
      mhs_pkg::S_POP_INIT: begin
        if ((SW + 1)'(2) <= {1'b0, pop_n}) begin
          state_nxt = mhs_pkg::S_DN_A;
        end else begin
          state_nxt = mhs_pkg::S_UP_START;
        end
      end
      mhs_pkg::S_DN_A, mhs_pkg::S_DN_B: begin
        if ((state_r == mhs_pkg::S_DN_A) && has_b) begin
          state_nxt = mhs_pkg::S_DN_B;
        end else if (sel_stop) begin
          state_nxt = mhs_pkg::S_UP_START;
        end else if (next_more) begin
          state_nxt = mhs_pkg::S_DN_A;
        end else begin
          state_nxt = mhs_pkg::S_DN_LAST;
        end
      end
      mhs_pkg::S_DN_LAST: begin
        state_nxt = mhs_pkg::S_UP_START;
      end
      mhs_pkg::S_UP_START: begin
        if (cnt_r == SW'(1)) begin
          state_nxt = mhs_pkg::S_EMIT;
        end else begin
          state_nxt = mhs_pkg::S_UP;
        end
      end
      mhs_pkg::S_UP: begin
        if (!push_lt) begin
          state_nxt = mhs_pkg::S_EMIT;
        end else if (up_idx == SW'(1)) begin
          state_nxt = mhs_pkg::S_UP_LAST;
        end
      end
      mhs_pkg::S_UP_LAST: begin
        state_nxt = mhs_pkg::S_EMIT;
      end
      mhs_pkg::S_EMIT: begin
        if (emit_ok) begin
          state_nxt = mhs_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mhs_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready      = (state_r == mhs_pkg::S_IDLE);
    cnt_nxt       = cnt_r;
    valid_nxt     = valid_r;
    len_nxt       = len_r;
    top_nxt       = top_r;
    last_nxt      = last_r;
    ca_nxt        = ca_r;
    parent_nxt    = parent_r;
    child_nxt     = child_r;
    idx_nxt       = idx_r;
    mtime_nxt     = mtime_r;
    end_nxt       = end_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_id_nxt    = out_id_r;
    out_start_nxt = out_start_r;
    out_end_nxt   = out_end_r;
    wr_en         = 1'b0;
    wr_slot       = parent_r;
    wr_data       = last_r;
    rd_slot       = SW'(1);

    unique case (state_r)
      mhs_pkg::S_IDLE: begin
        if (accept_in && (in_cmd == mhs_pkg::CMD_RESTART)) begin
          cnt_nxt   = mhs_pkg::clamp_count(cfg_num_r);
          valid_nxt = '0;
        end
        len_nxt = in_job_length;
      end
      mhs_pkg::S_RD_LAST: begin
        top_nxt = rd_entry;
        rd_slot = cnt_r;
      end
      mhs_pkg::S_POP_INIT: begin
        last_nxt   = rd_entry;
        parent_nxt = SW'(1);
        child_nxt  = SW'(2);
        rd_slot    = SW'(2);
        if (sum_full[TW]) begin
          mtime_nxt = mhs_pkg::TIME_MAX;
        end else begin
          mtime_nxt = sum_full[TW-1:0];
        end
        if (len_r == '0) begin
          end_nxt = (top_r.free_time == '0) ? '0 : top_r.free_time - TW'(1);
        end else if (end_sum[TW]) begin
          end_nxt = mhs_pkg::TIME_MAX;
        end else begin
          end_nxt = end_sum[TW-1:0];
        end
        if ((SW + 1)'(2) > {1'b0, pop_n}) begin
          wr_en   = 1'b1;
          wr_slot = SW'(1);
          wr_data = rd_entry;
        end
      end
      mhs_pkg::S_DN_A, mhs_pkg::S_DN_B: begin
        if ((state_r == mhs_pkg::S_DN_A) && has_b) begin
          ca_nxt  = rd_entry;
          rd_slot = child_r + SW'(1);
        end else if (sel_stop) begin
          wr_en   = 1'b1;
          wr_slot = parent_r;
          wr_data = last_r;
        end else begin
          wr_en      = 1'b1;
          wr_slot    = parent_r;
          wr_data    = sel_entry;
          parent_nxt = sel_idx;
          child_nxt  = next_child[SW-1:0];
          rd_slot    = next_child[SW-1:0];
        end
      end
      mhs_pkg::S_DN_LAST: begin
        wr_en   = 1'b1;
        wr_slot = parent_r;
        wr_data = last_r;
      end
      mhs_pkg::S_UP_START: begin
        idx_nxt = cnt_r;
        rd_slot = cnt_r >> 1;
        if (cnt_r == SW'(1)) begin
          wr_en   = 1'b1;
          wr_slot = SW'(1);
          wr_data = push_entry;
        end
      end
      mhs_pkg::S_UP: begin
        wr_en   = 1'b1;
        wr_slot = idx_r;
        if (push_lt) begin
          wr_data = rd_entry;
          idx_nxt = up_idx;
          rd_slot = up_idx >> 1;
        end else begin
          wr_data = push_entry;
        end
      end
      mhs_pkg::S_UP_LAST: begin
        wr_en   = 1'b1;
        wr_slot = SW'(1);
        wr_data = push_entry;
      end
      mhs_pkg::S_EMIT: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = mhs_pkg::ID_W'(top_r.id);
          out_start_nxt = top_r.free_time;
          out_end_nxt   = end_r;
        end
      end
      default: begin
      end
    endcase

    if (wr_en) begin
      valid_nxt[mhs_pkg::slot2addr(wr_slot)] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mhs_pkg::S_IDLE;
      cfg_num_r   <= mhs_pkg::CNT_W'(mhs_pkg::RESET_MACHINES);
      cnt_r       <= mhs_pkg::clamp_count(mhs_pkg::CNT_W'(mhs_pkg::RESET_MACHINES));
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_num_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    len_r       <= len_nxt;
    top_r       <= top_nxt;
    last_r      <= last_nxt;
    ca_r        <= ca_nxt;
    parent_r    <= parent_nxt;
    child_r     <= child_nxt;
    idx_r       <= idx_nxt;
    mtime_r     <= mtime_nxt;
    end_r       <= end_nxt;
    out_id_r    <= out_id_nxt;
    out_start_r <= out_start_nxt;
    out_end_r   <= out_end_nxt;
    rd_slot_r   <= rd_slot;
    rd_valid_r  <= valid_r[mhs_pkg::slot2addr(rd_slot)];
  end

  assign out_valid      = out_valid_r;
  assign out_machine_id = out_id_r;
  assign out_start_time = out_start_r;
  assign out_end_time   = out_end_r;

  // The heap always holds between one and the maximum number of machines.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) && (32'(cnt_r) <= mhs_pkg::MAX_MACHINES))
    else $error("heap count out of range");

  // A job transaction leaves the controller busy in the cycle after its acceptance.
  a_job_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept_in && (in_cmd == mhs_pkg::CMD_JOB)) |=> !in_ready)
    else $error("job accepted without leaving idle");

  // A new result only appears after the emit step of a job.
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == mhs_pkg::S_EMIT))
    else $error("result raised outside the emit step");

  // A restart never produces a result.
  a_restart_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (accept_in && (in_cmd == mhs_pkg::CMD_RESTART) && !out_valid_r) |=> !out_valid_r)
    else $error("restart produced a result");

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the min-heap job-to-machine scheduler
// Drives restart and job transactions through the valid/ready input channel,
// predicts each assignment with a behavioral heap of machine free times, and
// compares every result transaction field by field. A directed table covers
// the extremes and the typed-in cases. Random phases follow under several
// machine counts and idling patterns, with one long output hold-off. A short
// run on a single machine closes the test.
// ----------------------------------------------------------------------------
module tb;
  import mhs_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_JOBS    = 88;
  localparam logic [31:0] FREE_MAX = 32'hFFFF_FFFF;

  typedef enum logic [0:0] {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    logic [ID_W-1:0]   machine_id;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
  } result_t;

  typedef struct packed {
    row_kind_t        kind;
    logic             cmd;
    logic [LEN_W-1:0] len;
    logic [CNT_W-1:0] cfg_val;
    logic             typed;
    result_t          want;
  } dir_row_t;

  typedef struct packed {
    logic [7:0]        id;
    logic [TIME_W-1:0] free_time;
  } mach_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CNT_W-1:0]  cfg_wdata;
  logic              in_valid;
  logic              in_ready;
  logic              in_cmd;
  logic [LEN_W-1:0]  in_job_length;
  logic              out_valid;
  logic              out_ready;
  logic [ID_W-1:0]   out_machine_id;
  logic [TIME_W-1:0] out_start_time;
  logic [TIME_W-1:0] out_end_time;

  mach_t            sched_heap [1:MAX_MACHINES];
  int               heap_fill;
  logic [CNT_W-1:0] machines_cfg;

  result_t  assign_q [$];
  dir_row_t dir_table [$];

  int  errors;
  int  n_restarts;
  int  n_jobs;
  int  n_checked;
  int  cycle_count;
  int  send_idle_pct;
  int  recv_idle_pct;
  logic pressure_go;

  min_heap_job_to_machine_scheduler_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_job_length  (in_job_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_machine_id (out_machine_id),
    .out_start_time (out_start_time),
    .out_end_time   (out_end_time)
  );

  always #10 clk = ~clk;

  function automatic void heap_insert(input mach_t e);
    int i;
    if (heap_fill >= MAX_MACHINES) return;
    heap_fill++;
    i = heap_fill;
    while (i != 1 && e.free_time < sched_heap[i / 2].free_time) begin
      sched_heap[i] = sched_heap[i / 2];
      i = i / 2;
    end
    sched_heap[i] = e;
  endfunction

  function automatic mach_t heap_take();
    mach_t top;
    mach_t last;
    int    parent;
    int    child;
    top = sched_heap[1];
    last = sched_heap[heap_fill];
    heap_fill--;
    parent = 1;
    child = 2;
    while (child <= heap_fill) begin
      if (child < heap_fill && sched_heap[child].free_time > sched_heap[child + 1].free_time) begin
        child++;
      end
      if (sched_heap[child].free_time > last.free_time) break;
      sched_heap[parent] = sched_heap[child];
      parent = child;
      child = child * 2;
    end
    sched_heap[parent] = last;
    return top;
  endfunction

  function automatic void reload_machines();
    int    n;
    mach_t e;
    if (machines_cfg == 0) n = 1;
    else if (int'(machines_cfg) > MAX_MACHINES) n = MAX_MACHINES;
    else n = int'(machines_cfg);
    heap_fill = 0;
    for (int k = 1; k <= n; k++) begin
      e.id = 8'(k);
      e.free_time = '0;
      heap_insert(e);
    end
  endfunction

  function automatic bit predict_assignment(input logic cmd, input logic [LEN_W-1:0] len,
                                            output result_t res);
    mach_t       m;
    logic [32:0] sum;
    res = '0;
    if (cmd == CMD_RESTART) begin
      reload_machines();
      return 1'b0;
    end
    if (heap_fill == 0) return 1'b0;
    m = heap_take();
    res.machine_id = m.id[ID_W-1:0];
    res.start_time = m.free_time;
    if (len == 0) begin
      res.end_time = (m.free_time == 0) ? '0 : m.free_time - 32'd1;
    end else begin
      sum = {1'b0, m.free_time} + 33'(len) - 33'd1;
      res.end_time = sum[32] ? FREE_MAX : sum[31:0];
    end
    sum = {1'b0, m.free_time} + 33'(len);
    m.free_time = sum[32] ? FREE_MAX : sum[31:0];
    heap_insert(m);
    return 1'b1;
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    int sel;
    sel = $urandom_range(9);
    case (sel)
      0: return '0;
      1: return '1;
      2, 3, 4: return LEN_W'($urandom_range(1, 8));
      default: return LEN_W'($urandom);
    endcase
  endfunction

  task automatic add_item(input logic cmd, input logic [LEN_W-1:0] len, input logic typed,
                          input logic [ID_W-1:0] id, input logic [TIME_W-1:0] st,
                          input logic [TIME_W-1:0] en);
    dir_row_t r;
    r.kind = ROW_ITEM;
    r.cmd = cmd;
    r.len = len;
    r.cfg_val = '0;
    r.typed = typed;
    r.want.machine_id = id;
    r.want.start_time = st;
    r.want.end_time = en;
    dir_table.push_back(r);
  endtask

  task automatic add_cfg(input logic [CNT_W-1:0] v);
    dir_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.cfg_val = v;
    dir_table.push_back(r);
  endtask

  task automatic send_item(input logic cmd, input logic [LEN_W-1:0] len, input logic typed,
                           input result_t typed_res);
    result_t res;
    bit      has;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_job_length <= len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    has = predict_assignment(cmd, len, res);
    if (has) assign_q.push_back(typed ? typed_res : res);
    if (cmd == CMD_RESTART) n_restarts++;
    else n_jobs++;
  endtask

  task automatic write_machines(input logic [CNT_W-1:0] v);
    in_valid <= 1'b0;
    while (assign_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    machines_cfg = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (assign_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, actual id %0d start %0d end %0d",
                 $time, out_machine_id, out_start_time, out_end_time);
      end else begin
        want = assign_q.pop_front();
        n_checked++;
        check_field("machine_id", 32'(want.machine_id), 32'(out_machine_id));
        check_field("start_time", want.start_time, out_start_time);
        check_field("end_time", want.end_time, out_end_time);
      end
    end
  end

  initial begin
    int hold_count;
    out_ready = 1'b0;
    hold_count = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (pressure_go && hold_count < HOLD_CYCLES) begin
        out_ready <= 1'b0;
        hold_count++;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
      @(posedge clk);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding.",
             cycle_count, assign_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    dir_row_t         row;
    logic [CNT_W-1:0] phase_cfg [9];
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_cmd = CMD_RESTART;
    in_job_length = '0;
    pressure_go = 1'b0;
    errors = 0;
    n_restarts = 0;
    n_jobs = 0;
    n_checked = 0;
    cycle_count = 0;
    send_idle_pct = 6;
    recv_idle_pct = 59;
    machines_cfg = CNT_W'(RESET_MACHINES);
    reload_machines();

    add_item(CMD_JOB, 16'd10, 1'b1, 5'd1, 32'd0, 32'd9);
    add_item(CMD_JOB, 16'd1, 1'b1, 5'd2, 32'd0, 32'd0);
    add_item(CMD_JOB, 16'd0, 1'b1, 5'd3, 32'd0, 32'd0);
    add_item(CMD_JOB, 16'hFFFF, 1'b1, 5'd3, 32'd0, 32'd65534);
    add_item(CMD_JOB, 16'd0, 1'b1, 5'd2, 32'd1, 32'd0);
    add_item(CMD_RESTART, 16'hFFFF, 1'b0, '0, '0, '0);
    add_item(CMD_JOB, 16'h8000, 1'b1, 5'd1, 32'd0, 32'd32767);
    add_item(CMD_JOB, 16'h7FFF, 1'b0, '0, '0, '0);
    add_cfg(5'd0);
    add_item(CMD_RESTART, 16'h0000, 1'b0, '0, '0, '0);
    add_item(CMD_JOB, 16'd100, 1'b1, 5'd1, 32'd0, 32'd99);
    add_item(CMD_JOB, 16'hFFFF, 1'b1, 5'd1, 32'd100, 32'd65634);
    add_item(CMD_JOB, 16'd0, 1'b1, 5'd1, 32'd65635, 32'd65634);
    add_cfg(5'd31);
    add_item(CMD_RESTART, 16'h5555, 1'b0, '0, '0, '0);
    add_item(CMD_JOB, 16'd5, 1'b1, 5'd1, 32'd0, 32'd4);
    add_item(CMD_JOB, 16'hAAAA, 1'b0, '0, '0, '0);
    add_item(CMD_JOB, 16'h5555, 1'b0, '0, '0, '0);
    add_item(CMD_JOB, 16'd1, 1'b0, '0, '0, '0);
    add_item(CMD_JOB, 16'd1, 1'b0, '0, '0, '0);
    add_item(CMD_JOB, 16'd0, 1'b0, '0, '0, '0);
    add_cfg(5'd16);
    add_item(CMD_RESTART, 16'hAAAA, 1'b0, '0, '0, '0);
    add_item(CMD_JOB, 16'd3, 1'b1, 5'd1, 32'd0, 32'd2);
    add_item(CMD_JOB, 16'd2, 1'b0, '0, '0, '0);

    phase_cfg = '{5'd2, 5'd16, 5'd7, 5'd1, 5'd31, 5'd5, 5'd0, 5'd12, 5'd17};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < dir_table.size(); i++) begin
      row = dir_table[i];
      if (row.kind == ROW_CFG) write_machines(row.cfg_val);
      else send_item(row.cmd, row.len, row.typed, row.want);
    end

    for (int p = 0; p < 9; p++) begin
      write_machines(phase_cfg[p]);
      case (p / 3)
        0: begin
          send_idle_pct = 6;
          recv_idle_pct = 59;
        end
        1: begin
          send_idle_pct = 59;
          recv_idle_pct = 6;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      send_item(CMD_RESTART, LEN_W'($urandom), 1'b0, '0);
      if (p == 0) pressure_go <= 1'b1;
      for (int j = 0; j < PHASE_JOBS; j++) begin
        if ($urandom_range(99) < 3) send_item(CMD_RESTART, LEN_W'($urandom), 1'b0, '0);
        else send_item(CMD_JOB, pick_length(), 1'b0, '0);
      end
    end

    write_machines(5'd1);
    send_item(CMD_RESTART, 16'd0, 1'b0, '0);
    send_item(CMD_JOB, 16'h1234, 1'b0, '0);
    send_item(CMD_JOB, 16'd0, 1'b0, '0);
    send_item(CMD_JOB, 16'd1, 1'b0, '0);
    repeat (4) send_item(CMD_JOB, pick_length(), 1'b0, '0);

    in_valid <= 1'b0;
    while (assign_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d transactions: %0d restarts and %0d jobs, %0d results checked.",
             n_restarts + n_jobs, n_restarts, n_jobs, n_checked);
    $display("Machine counts between 1 and 16 were used, with out-of-range settings clamped.");
    if (errors == 0 && assign_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/mhs_pkg.sv
rtl/mhs_ram.sv
rtl/min_heap_job_to_machine_scheduler_unit.sv
sim/tb.sv
